FILE: design/dbcd_pkg.sv
// ----------------------------------------------------------------------------
// dbcd_pkg: shared types and constants for the dual button chord detector
// Operation codes, state codes, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package dbcd_pkg;

  // Input operation codes
  localparam logic [1:0] OP_BUTTON1 = 2'd0;
  localparam logic [1:0] OP_BUTTON2 = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  // Result event codes
  localparam logic [1:0] EV_DUAL      = 2'd0;
  localparam logic [1:0] EV_CONFIRMED = 2'd1;
  localparam logic [1:0] EV_CANCELLED = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PRESS_WINDOW    = 2'd0;
  localparam logic [1:0] REG_HOLD_TIME       = 2'd1;
  localparam logic [1:0] REG_SAMPLE_INTERVAL = 2'd2;

  // Configuration reset values
  localparam logic [15:0] PRESS_WINDOW_RESET    = 16'd500;
  localparam logic [15:0] HOLD_TIME_RESET       = 16'd3000;
  localparam logic [15:0] SAMPLE_INTERVAL_RESET = 16'd50;

  // Detector states
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_B1_PENDING = 3'd1,
    ST_B2_PENDING = 3'd2,
    ST_DUAL       = 3'd3,
    ST_HOLD       = 3'd4
  } detect_state_t;

endpackage

FILE: design/dual_button_chord_detector.sv
// ----------------------------------------------------------------------------
// dual_button_chord_detector: two-button chord and hold detector
// Tracks presses of two buttons and sampled levels, reports dual/hold/cancel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item per handshake: op
//   selects button one press, button two press or update tick; now_ms is the
//   wrapping millisecond time; the active-low levels count on ticks only.
//   Output channel (out_valid/out_stall) carries event_code: dual press,
//   hold confirmed or dual press cancelled. An item gives zero or one result.
//   An accepted item is held in the input register; its result, if any, is
//   loaded into the result register when the item leaves it.
//   The block takes one item per cycle while the receiver does not stall, via
//   the combinational compare and update logic between the two registers.
//   When the receiver stalls with a result waiting, the input register holds
//   its item and in_stall rises; nothing is dropped.
//   The user must write configuration (cfg_wen/cfg_index/cfg_data) only while
//   idle; the block does not enforce it. Index 3 is ignored.
//   Reset (rst, synchronous) returns to idle, clears all times and held
//   flags, and loads the default window, hold time and sample interval.
module dual_button_chord_detector (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] now_ms,
  input  logic        button1_level,
  input  logic        button2_level,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_code
);

  // Configuration registers
  logic [15:0] press_window_ms;
  logic [15:0] hold_time_ms;
  logic [15:0] sample_interval_ms;

  // Input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [31:0] s1_now;
  logic        s1_lvl1;
  logic        s1_lvl2;

  // Detector state
  dbcd_pkg::detect_state_t detect_state, detect_state_next;
  logic [31:0] state_entry_ms, state_entry_ms_next;
  logic [31:0] button1_press_ms, button1_press_ms_next;
  logic [31:0] button2_press_ms, button2_press_ms_next;
  logic [31:0] dual_start_ms, dual_start_ms_next;
  logic [31:0] last_sample_ms, last_sample_ms_next;
  logic        button1_held, button1_held_next;
  logic        button2_held, button2_held_next;

  // Result of the item in the input register
  logic        res_valid;
  logic [1:0]  res_code;

  // Handshake control
  logic out_free;
  logic advance;
  logic in_fire;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_fire  = in_valid && !in_stall;

  // Differences, wrapping modulo 2^32
  logic [31:0] d_sample, d_entry, d_dual, d_b1, d_b2;
  logic        sample_now, b1_in_window, b2_in_window;

  assign d_sample     = s1_now - last_sample_ms;
  assign d_entry      = s1_now - state_entry_ms;
  assign d_dual       = s1_now - dual_start_ms;
  assign d_b1         = s1_now - button1_press_ms;
  assign d_b2         = s1_now - button2_press_ms;
  assign sample_now   = d_sample >= {16'd0, sample_interval_ms};
  assign b1_in_window = d_b1 <= {16'd0, press_window_ms};
  assign b2_in_window = d_b2 <= {16'd0, press_window_ms};

  // Config write
  always_ff @(posedge clk) begin
    if (rst) begin
      press_window_ms    <= dbcd_pkg::PRESS_WINDOW_RESET;
      hold_time_ms       <= dbcd_pkg::HOLD_TIME_RESET;
      sample_interval_ms <= dbcd_pkg::SAMPLE_INTERVAL_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        dbcd_pkg::REG_PRESS_WINDOW:    press_window_ms    <= cfg_data;
        dbcd_pkg::REG_HOLD_TIME:       hold_time_ms       <= cfg_data;
        dbcd_pkg::REG_SAMPLE_INTERVAL: sample_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load the input register; hold it while the result side is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op   <= op;
      s1_now  <= now_ms;
      s1_lvl1 <= button1_level;
      s1_lvl2 <= button2_level;
    end
  end

  // Next state of the detector
  always_comb begin
    detect_state_next     = detect_state;
    state_entry_ms_next   = state_entry_ms;
    button1_press_ms_next = button1_press_ms;
    button2_press_ms_next = button2_press_ms;
    dual_start_ms_next    = dual_start_ms;
    last_sample_ms_next   = last_sample_ms;
    button1_held_next     = button1_held;
    button2_held_next     = button2_held;
    res_valid             = 1'b0;
    res_code              = dbcd_pkg::EV_DUAL;

    case (s1_op)
      dbcd_pkg::OP_BUTTON1, dbcd_pkg::OP_BUTTON2: begin
        case (detect_state)
          dbcd_pkg::ST_B1_PENDING: begin
            if (s1_op == dbcd_pkg::OP_BUTTON2) begin
              button2_press_ms_next = s1_now;
              if (b1_in_window) begin
                dual_start_ms_next  = s1_now;
                detect_state_next   = dbcd_pkg::ST_DUAL;
                state_entry_ms_next = s1_now;
                res_valid           = 1'b1;
              end else begin
                detect_state_next     = dbcd_pkg::ST_IDLE;
                state_entry_ms_next   = '0;
                button1_press_ms_next = '0;
                button2_press_ms_next = '0;
                dual_start_ms_next    = '0;
                button1_held_next     = 1'b0;
                button2_held_next     = 1'b0;
              end
            end
          end
          dbcd_pkg::ST_B2_PENDING: begin
            if (s1_op == dbcd_pkg::OP_BUTTON1) begin
              button1_press_ms_next = s1_now;
              if (b2_in_window) begin
                dual_start_ms_next  = s1_now;
                detect_state_next   = dbcd_pkg::ST_DUAL;
                state_entry_ms_next = s1_now;
                res_valid           = 1'b1;
              end else begin
                detect_state_next     = dbcd_pkg::ST_IDLE;
                state_entry_ms_next   = '0;
                button1_press_ms_next = '0;
                button2_press_ms_next = '0;
                dual_start_ms_next    = '0;
                button1_held_next     = 1'b0;
                button2_held_next     = 1'b0;
              end
            end
          end
          dbcd_pkg::ST_DUAL, dbcd_pkg::ST_HOLD: ;
          default: begin
            // idle, and any unused code: arm the pending state
            state_entry_ms_next = s1_now;
            if (s1_op == dbcd_pkg::OP_BUTTON1) begin
              button1_press_ms_next = s1_now;
              detect_state_next     = dbcd_pkg::ST_B1_PENDING;
            end else begin
              button2_press_ms_next = s1_now;
              detect_state_next     = dbcd_pkg::ST_B2_PENDING;
            end
          end
        endcase
      end
      dbcd_pkg::OP_TICK: begin
        // sample the levels at most once per interval
        if (sample_now) begin
          button1_held_next   = !s1_lvl1;
          button2_held_next   = !s1_lvl2;
          last_sample_ms_next = s1_now;
        end
        case (detect_state)
          dbcd_pkg::ST_B1_PENDING, dbcd_pkg::ST_B2_PENDING: begin
            if (d_entry >= {16'd0, press_window_ms}) begin
              detect_state_next     = dbcd_pkg::ST_IDLE;
              state_entry_ms_next   = '0;
              button1_press_ms_next = '0;
              button2_press_ms_next = '0;
              dual_start_ms_next    = '0;
              button1_held_next     = 1'b0;
              button2_held_next     = 1'b0;
            end
          end
          dbcd_pkg::ST_DUAL: begin
            detect_state_next   = dbcd_pkg::ST_HOLD;
            state_entry_ms_next = s1_now;
          end
          dbcd_pkg::ST_HOLD: begin
            // release is checked before the hold time
            if (!(button1_held_next && button2_held_next)) begin
              res_valid = 1'b1;
              res_code  = dbcd_pkg::EV_CANCELLED;
            end else if (d_dual >= {16'd0, hold_time_ms}) begin
              res_valid = 1'b1;
              res_code  = dbcd_pkg::EV_CONFIRMED;
            end
            if (res_valid) begin
              detect_state_next     = dbcd_pkg::ST_IDLE;
              state_entry_ms_next   = '0;
              button1_press_ms_next = '0;
              button2_press_ms_next = '0;
              dual_start_ms_next    = '0;
              button1_held_next     = 1'b0;
              button2_held_next     = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Update the detector state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      detect_state     <= dbcd_pkg::ST_IDLE;
      state_entry_ms   <= '0;
      button1_press_ms <= '0;
      button2_press_ms <= '0;
      dual_start_ms    <= '0;
      last_sample_ms   <= '0;
      button1_held     <= 1'b0;
      button2_held     <= 1'b0;
    end else if (advance) begin
      detect_state     <= detect_state_next;
      state_entry_ms   <= state_entry_ms_next;
      button1_press_ms <= button1_press_ms_next;
      button2_press_ms <= button2_press_ms_next;
      dual_start_ms    <= dual_start_ms_next;
      last_sample_ms   <= last_sample_ms_next;
      button1_held     <= button1_held_next;
      button2_held     <= button2_held_next;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      event_code <= res_code;
    end
  end

endmodule

FILE: tb/tb_dual_button_chord_detector.sv
// ----------------------------------------------------------------------------
// tb_dual_button_chord_detector: self-checking bench for the chord detector
// Runs a short directed table, then random chord sequences and noise over
// several register settings. Both channels idle and stall at random. Every
// result is checked against the in-bench model or a row's typed expectation.
// ----------------------------------------------------------------------------
module tb_dual_button_chord_detector;

  // codes that the package leaves unnamed
  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int NUM_PHASES      = 10;
  localparam int PHASE_ITEMS     = 140;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_REPORTS     = 10;

  // DUT ports; the inputs are known from time zero
  logic        clk;
  logic        rst           = 1'b1;
  logic        cfg_wen       = 1'b0;
  logic [1:0]  cfg_index     = dbcd_pkg::REG_PRESS_WINDOW;
  logic [15:0] cfg_data      = '0;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  op            = dbcd_pkg::OP_TICK;
  logic [31:0] now_ms        = '0;
  logic        button1_level = 1'b1;
  logic        button2_level = 1'b1;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic [1:0]  event_code;

  // typed expectation that travels with a directed row
  logic        row_typed = 1'b0;
  logic        row_fires = 1'b0;
  logic [1:0]  row_code  = dbcd_pkg::EV_DUAL;

  // chord model state and its copy of the registers
  dbcd_pkg::detect_state_t det_st;
  logic [31:0]   entry_ms, b1_ms, b2_ms, dual_ms, sample_ms;
  logic          held1, held2;
  logic [15:0]   win_ms, hold_ms, smp_ms;

  logic [1:0] pending_events [$];
  int         err_count      = 0;
  int         events_checked = 0;
  int         rand_items     = 0;
  int         code_seen [0:3];
  logic [31:0] clock_ms      = '0;
  bit         steady         = 1'b0;
  int         holdoffs_asked = 0;
  int         holdoffs_done  = 0;

  typedef struct {
    logic [1:0]  opc;
    logic [31:0] t;
    logic        l1;
    logic        l2;
    logic        typed;
    logic        fires;
    logic [1:0]  code;
  } stim_row_t;

  stim_row_t dir_rows [0:23];

  dual_button_chord_detector u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .now_ms        (now_ms),
    .button1_level (button1_level),
    .button2_level (button2_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_code    (event_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic void clear_to_idle();
    det_st   = dbcd_pkg::ST_IDLE;
    entry_ms = '0;
    b1_ms    = '0;
    b2_ms    = '0;
    dual_ms  = '0;
    held1    = 1'b0;
    held2    = 1'b0;
  endfunction

  function automatic void chord_reset();
    clear_to_idle();
    sample_ms = '0;
    win_ms    = dbcd_pkg::PRESS_WINDOW_RESET;
    hold_ms   = dbcd_pkg::HOLD_TIME_RESET;
    smp_ms    = dbcd_pkg::SAMPLE_INTERVAL_RESET;
  endfunction

  function automatic void enter_state(input dbcd_pkg::detect_state_t s,
                                      input logic [31:0] t);
    if (det_st != s) begin
      det_st   = s;
      entry_ms = t;
    end
  endfunction

  // second button arrived; a dual press only inside the window
  function automatic logic pair_press(input logic [31:0] first_t, input logic [31:0] t);
    logic [31:0] gap;
    gap = t - first_t;
    if (gap <= {16'd0, win_ms}) begin
      dual_ms = t;
      enter_state(dbcd_pkg::ST_DUAL, t);
      return 1'b1;
    end
    clear_to_idle();
    return 1'b0;
  endfunction

  // advance the model by one item; return 1 with code when it reports
  function automatic logic chord_step(input logic [1:0] opc, input logic [31:0] t,
                                      input logic l1, input logic l2,
                                      output logic [1:0] code);
    logic [31:0] dt;
    code = dbcd_pkg::EV_DUAL;
    if (opc == dbcd_pkg::OP_BUTTON1 || opc == dbcd_pkg::OP_BUTTON2) begin
      if (det_st == dbcd_pkg::ST_B1_PENDING && opc == dbcd_pkg::OP_BUTTON2) begin
        b2_ms = t;
        return pair_press(b1_ms, t);
      end else if (det_st == dbcd_pkg::ST_B2_PENDING && opc == dbcd_pkg::OP_BUTTON1) begin
        b1_ms = t;
        return pair_press(b2_ms, t);
      end else if (det_st == dbcd_pkg::ST_IDLE) begin
        if (opc == dbcd_pkg::OP_BUTTON1) begin
          b1_ms = t;
          enter_state(dbcd_pkg::ST_B1_PENDING, t);
        end else begin
          b2_ms = t;
          enter_state(dbcd_pkg::ST_B2_PENDING, t);
        end
      end
      return 1'b0;
    end
    if (opc != dbcd_pkg::OP_TICK) return 1'b0;

    // sample the active-low levels at most once per interval
    dt = t - sample_ms;
    if (dt >= {16'd0, smp_ms}) begin
      held1     = ~l1;
      held2     = ~l2;
      sample_ms = t;
    end

    case (det_st)
      dbcd_pkg::ST_B1_PENDING, dbcd_pkg::ST_B2_PENDING: begin
        dt = t - entry_ms;
        if (dt >= {16'd0, win_ms}) clear_to_idle();
      end
      dbcd_pkg::ST_DUAL: enter_state(dbcd_pkg::ST_HOLD, t);
      dbcd_pkg::ST_HOLD: begin
        // a release wins over an elapsed hold time
        dt = t - dual_ms;
        if (!(held1 && held2)) begin
          clear_to_idle();
          code = dbcd_pkg::EV_CANCELLED;
          return 1'b1;
        end
        if (dt >= {16'd0, hold_ms}) begin
          clear_to_idle();
          code = dbcd_pkg::EV_CONFIRMED;
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------- checker
  task automatic note_failure(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin : event_monitor
    logic [1:0] code;
    logic       fired;
    logic [1:0] want;
    // check a delivered result against the oldest expectation
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        note_failure($sformatf("unexpected event_code %0d", event_code));
      end else begin
        want = pending_events.pop_front();
        if (want !== event_code)
          note_failure($sformatf("event_code expected %0d, got %0d", want, event_code));
      end
      events_checked++;
      if (!$isunknown(event_code)) code_seen[event_code]++;
    end
    // predict the result of an accepted item
    if (!rst && in_valid && !in_stall) begin
      fired = chord_step(op, now_ms, button1_level, button2_level, code);
      if (row_typed) begin
        fired = row_fires;
        code  = row_code;
      end
      if (fired) pending_events.push_back(code);
    end
  end

  // end the run when nothing moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("ERROR: no item moved for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_events.size());
    $display("dual_button_chord_detector: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- drivers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // receiver: random stalls, and a long hold-off when asked
  initial begin : receiver
    int n;
    forever begin
      if (holdoffs_done != holdoffs_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        holdoffs_done++;
      end else begin
        n = steady ? 0 : pick_gap();
        out_stall <= (n != 0);
        repeat ((n == 0) ? 1 : n) @(posedge clk);
      end
    end
  end

  // offer one item, hold it until taken, then maybe idle
  task automatic offer(input logic [1:0] opc, input logic [31:0] t,
                       input logic l1, input logic l2,
                       input logic typed, input logic fires, input logic [1:0] code);
    int n;
    op            <= opc;
    now_ms        <= t;
    button1_level <= l1;
    button2_level <= l2;
    row_typed     <= typed;
    row_fires     <= fires;
    row_code      <= code;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n = steady ? 0 : pick_gap();
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic offer_rand(input logic [1:0] opc, input logic [31:0] t,
                            input logic l1, input logic l2);
    offer(opc, t, l1, l2, 1'b0, 1'b0, dbcd_pkg::EV_DUAL);
    if (opc != OP_UNUSED) rand_items++;
  endtask

  // well-formed chord: first press, maybe a repeat and a tick, second press, ticks
  task automatic run_chord();
    logic [1:0]  first_op, second_op;
    int unsigned w, h, s, span, r;
    w = 32'(win_ms);
    h = 32'(hold_ms);
    s = 32'(smp_ms);
    first_op  = $urandom_range(0, 1) ? dbcd_pkg::OP_BUTTON2 : dbcd_pkg::OP_BUTTON1;
    second_op = (first_op == dbcd_pkg::OP_BUTTON1) ? dbcd_pkg::OP_BUTTON2
                                                   : dbcd_pkg::OP_BUTTON1;
    clock_ms += $urandom_range(0, s + 8);
    offer_rand(first_op, clock_ms, 1'($urandom()), 1'($urandom()));
    if ($urandom_range(0, 3) == 0) begin
      clock_ms += $urandom_range(0, w / 2);
      offer_rand(first_op, clock_ms, 1'($urandom()), 1'($urandom()));
    end
    if ($urandom_range(0, 4) == 0) begin
      clock_ms += $urandom_range(0, w + 2);
      offer_rand(dbcd_pkg::OP_TICK, clock_ms, 1'($urandom()), 1'($urandom()));
    end
    // second press, often right at the window edge
    r = $urandom_range(0, 9);
    if (r == 0) span = w;
    else if (r == 1) span = w + 1;
    else span = $urandom_range(0, w + w / 4 + 2);
    clock_ms += span;
    offer_rand(second_op, clock_ms, 1'($urandom()), 1'($urandom()));
    // ticks through the hold check, now and then with a release
    repeat ($urandom_range(1, 10)) begin
      clock_ms += $urandom_range(0, h / 3 + s + 2);
      r = $urandom_range(0, 11);
      offer_rand(dbcd_pkg::OP_TICK, clock_ms, r == 0, r == 1);
    end
  endtask

  task automatic run_noise();
    logic [1:0]  opc;
    logic [31:0] t;
    opc = 2'($urandom_range(0, 3));
    t   = $urandom_range(0, 1) ? 32'($urandom()) : clock_ms + $urandom_range(0, 64);
    offer_rand(opc, t, 1'($urandom()), 1'($urandom()));
  endtask

  // wait until all results are in and the pipeline is empty
  task automatic settle();
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [15:0] w, input logic [15:0] h,
                             input logic [15:0] s);
    cfg_wen   <= 1'b1;
    cfg_index <= dbcd_pkg::REG_PRESS_WINDOW;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= dbcd_pkg::REG_HOLD_TIME;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= dbcd_pkg::REG_SAMPLE_INTERVAL;
    cfg_data  <= s;
    @(posedge clk);
    // the spare index must be ignored
    cfg_index <= REG_UNUSED;
    cfg_data  <= 16'($urandom());
    @(posedge clk);
    cfg_wen <= 1'b0;
    win_ms  = w;
    hold_ms = h;
    smp_ms  = s;
  endtask

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int          base;
    bit          asked;
    logic [15:0] w, h, s;

    foreach (code_seen[i]) code_seen[i] = 0;
    // reset window 500, hold 3000, sample 50
    dir_rows = '{
      // spare op
      '{OP_UNUSED, 32'd0, 1'b1, 1'b1, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      // idle tick
      '{dbcd_pkg::OP_TICK, 32'd0, 1'b1, 1'b1, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      // arm
      '{dbcd_pkg::OP_BUTTON1, 32'd1000, 1'b0, 1'b0, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      // repeat
      '{dbcd_pkg::OP_BUTTON1, 32'd1100, 1'b0, 1'b1, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      // window edge
      '{dbcd_pkg::OP_BUTTON2, 32'd1500, 1'b1, 1'b0, 1'b1, 1'b1, dbcd_pkg::EV_DUAL},
      // ignored
      '{dbcd_pkg::OP_BUTTON1, 32'd1600, 1'b1, 1'b1, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_TICK, 32'd1600, 1'b0, 1'b0, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_TICK, 32'd1620, 1'b1, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // hold met
      '{dbcd_pkg::OP_TICK, 32'd4500, 1'b0, 1'b0, 1'b1, 1'b1, dbcd_pkg::EV_CONFIRMED},
      '{dbcd_pkg::OP_BUTTON2, 32'd5000, 1'b1, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // too late
      '{dbcd_pkg::OP_BUTTON1, 32'd5501, 1'b0, 1'b0, 1'b1, 1'b0, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_BUTTON2, 32'd6000, 1'b0, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_TICK, 32'd6499, 1'b1, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // times out
      '{dbcd_pkg::OP_TICK, 32'd6500, 1'b1, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_BUTTON1, 32'd7000, 1'b1, 1'b0, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // same ms
      '{dbcd_pkg::OP_BUTTON2, 32'd7000, 1'b0, 1'b0, 1'b1, 1'b1, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_TICK, 32'd7100, 1'b0, 1'b0, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // b2 up
      '{dbcd_pkg::OP_TICK, 32'd7200, 1'b0, 1'b1, 1'b1, 1'b1, dbcd_pkg::EV_CANCELLED},
      '{dbcd_pkg::OP_BUTTON2, 32'hFFFFFF00, 1'b1, 1'b1, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // wraps
      '{dbcd_pkg::OP_BUTTON1, 32'h000000F0, 1'b1, 1'b1, 1'b1, 1'b1, dbcd_pkg::EV_DUAL},
      '{dbcd_pkg::OP_TICK, 32'h00000100, 1'b0, 1'b0, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // not sampled
      '{dbcd_pkg::OP_TICK, 32'h00000101, 1'b1, 1'b0, 1'b0, 1'b0, dbcd_pkg::EV_DUAL},
      // cancel first
      '{dbcd_pkg::OP_TICK, 32'h00000D00, 1'b1, 1'b0, 1'b1, 1'b1, dbcd_pkg::EV_CANCELLED},
      '{OP_UNUSED, 32'hFFFFFFFF, 1'b0, 1'b0, 1'b1, 1'b0, dbcd_pkg::EV_DUAL}
    };
    chord_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (dir_rows[i])
      offer(dir_rows[i].opc, dir_rows[i].t, dir_rows[i].l1, dir_rows[i].l2,
            dir_rows[i].typed, dir_rows[i].fires, dir_rows[i].code);

    // random phases, one register setting each
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      in_valid <= 1'b0;
      settle();
      case (phase)
        0: begin w = 16'd0;     h = 16'd0;     s = 16'd0;     end
        1: begin w = 16'hFFFF;  h = 16'hFFFF;  s = 16'hFFFF;  end
        2: begin w = 16'hFFFF;  h = 16'd0;     s = 16'hFFFF;  end
        3: begin w = 16'd0;     h = 16'hFFFF;  s = 16'd0;     end
        default: begin
          w = 16'($urandom_range(0, 300));
          h = 16'($urandom_range(0, 400));
          s = 16'($urandom_range(0, 40));
        end
      endcase
      load_config(w, h, s);
      steady   = (phase == 1 || phase == 6);
      clock_ms = (phase % 3 == 0) ? 32'hFFFFFFFF - $urandom_range(0, 200000)
                                  : 32'($urandom());
      base  = rand_items;
      asked = 1'b0;
      while (rand_items - base < PHASE_ITEMS) begin
        // hold the receiver off while chords keep coming
        if ((phase == 5 || phase == 8) && !asked && rand_items - base >= 40) begin
          holdoffs_asked++;
          asked = 1'b1;
        end
        if ($urandom_range(0, 4) == 0) run_noise();
        else run_chord();
      end
    end

    in_valid <= 1'b0;
    settle();
    $display("covered %0d directed rows and %0d random items over %0d register settings",
             $size(dir_rows), rand_items, NUM_PHASES + 1);
    $display("checked %0d results (dual %0d, confirmed %0d, cancelled %0d), %0d failures",
             events_checked, code_seen[dbcd_pkg::EV_DUAL], code_seen[dbcd_pkg::EV_CONFIRMED],
             code_seen[dbcd_pkg::EV_CANCELLED], err_count);
    if (err_count == 0) $display("dual_button_chord_detector: match");
    else $display("dual_button_chord_detector: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
design/dbcd_pkg.sv
design/dual_button_chord_detector.sv
tb/tb_dual_button_chord_detector.sv
